// ===== sv/mwo_pkg.sv =====
// ----------------------------------------------------------------------------
// mwo_pkg
// shared types and constants of the morphing wavetable oscillator
// ----------------------------------------------------------------------------
package mwo_pkg;

  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 12;
  localparam int MORPH_W  = 12;
  localparam int FRAC_W   = 12;
  localparam int TW_W     = FRAC_W + 1;   // q12 weight including 1.0

  localparam int OUT_MAX  = 2047;
  localparam int OUT_MIN  = -2048;
  localparam logic [MORPH_W-1:0] MORPH_TOP = 12'd4095;
  localparam logic [TW_W-1:0]    Q12_ONE   = 13'd4096;
  localparam int OUT_SHIFT = 4;

  // sequencer steps inside the run state
  localparam int STEP_W       = 4;
  localparam int NUM_READS    = 8;
  localparam logic [STEP_W-1:0] STEP_MIX_X = 4'd9;
  localparam logic [STEP_W-1:0] STEP_MIX_Y = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POS,
    ST_RUN,
    ST_FIN
  } state_t;

endpackage

// ===== sv/mwo_ram.sv =====
// ----------------------------------------------------------------------------
// mwo_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mwo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/morphing_wavetable_oscillator.sv =====
// a tick item goes through the position step, the run steps and the finish state before
// out_valid rises, waiting in finish while the previous result is stalled; a write item gives no result
// no new item is taken while a tick is in progress, its work being eight sample reads through
// the single wave memory read port plus phase, mix and output steps; writes every cycle while idle
// reset clears the phase accumulator and control; wave memory holds no reset value
// ----------------------------------------------------------------------------
// morphing_wavetable_oscillator
// phase accumulator driving a two-axis interpolated read of a banked wave memory
// ----------------------------------------------------------------------------
module morphing_wavetable_oscillator #(
  parameter int NUM_WAVES = 16,
  parameter int TABLE_LEN = 256,
  parameter int NUM_BANKS = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic [31:0]                         phase_step,
  input  logic                                alt_bank,
  input  logic [mwo_pkg::MORPH_W-1:0]         morph_x,
  input  logic [mwo_pkg::MORPH_W-1:0]         morph_y,
  input  logic                                load_bank,
  input  logic [3:0]                          load_wave,
  input  logic [7:0]                          load_slot,
  input  logic signed [mwo_pkg::SAMPLE_W-1:0] load_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mwo_pkg::OUT_W-1:0]    first_out,
  output logic signed [mwo_pkg::OUT_W-1:0]    second_out
);

  localparam int DEPTH  = NUM_BANKS * NUM_WAVES * TABLE_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WAVE_W = $clog2(NUM_WAVES);
  localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int SLOT_W = $clog2(TABLE_LEN);
  localparam int LEN_W  = $clog2(TABLE_LEN + 1);
  localparam int POS_W  = 32 + LEN_W;
  localparam int P_W    = mwo_pkg::MORPH_W + WAVE_W;
  localparam int SW     = mwo_pkg::SAMPLE_W;
  localparam int TW     = mwo_pkg::TW_W;
  localparam int FW     = mwo_pkg::FRAC_W;

  mwo_pkg::state_t state, state_next;

  logic [mwo_pkg::STEP_W-1:0] cnt;
  logic [31:0]                phase_acc;
  logic [BANK_W-1:0]          bank;
  logic [WAVE_W-1:0]          wx, wy;
  logic [TW-1:0]              fx, fy;
  logic [SLOT_W-1:0]          si, sn;
  logic [TW-1:0]              sf;
  logic                       rd_valid;
  logic [2:0]                 rd_tag;
  logic signed [SW-1:0]       hold;
  logic signed [SW-1:0]       ph [4];
  logic signed [mwo_pkg::OUT_W-1:0] res_x;
  logic signed [mwo_pkg::OUT_W-1:0] res_y;

  logic tick_acc, write_acc, wr_ok, issue, load_out;

  // morph position to wave index and q12 weight
  function automatic logic [WAVE_W+TW-1:0] pick_wave(input logic [mwo_pkg::MORPH_W-1:0] m);
    logic [P_W-1:0]    p;
    logic [WAVE_W-1:0] idx;
    logic [TW-1:0]     frac;
    p   = P_W'(m) * P_W'(NUM_WAVES - 1);
    idx = p[P_W-1:FW];
    if (32'(idx) > NUM_WAVES - 2) begin
      idx = WAVE_W'(NUM_WAVES - 2);
    end
    frac = (m == mwo_pkg::MORPH_TOP) ? mwo_pkg::Q12_ONE : {1'b0, p[FW-1:0]};
    return {idx, frac};
  endfunction

  // ---------------- control ----------------
  always_comb begin
    state_next = state;
    case (state)
      mwo_pkg::ST_IDLE: if (in_valid && !kind) state_next = mwo_pkg::ST_POS;
      mwo_pkg::ST_POS:  state_next = mwo_pkg::ST_RUN;
      mwo_pkg::ST_RUN:  if (cnt == mwo_pkg::STEP_MIX_Y) state_next = mwo_pkg::ST_FIN;
      mwo_pkg::ST_FIN:  if (!out_valid || out_ready) state_next = mwo_pkg::ST_IDLE;
      default:          state_next = mwo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == mwo_pkg::ST_IDLE);
    issue    = (state == mwo_pkg::ST_RUN) && (32'(cnt) < mwo_pkg::NUM_READS);
    load_out = (state == mwo_pkg::ST_FIN) && (!out_valid || out_ready);
  end

  assign tick_acc  = in_valid && in_ready && !kind;
  assign write_acc = in_valid && in_ready && kind;
  assign wr_ok     = (32'(load_bank) < NUM_BANKS) && (32'(load_wave) < NUM_WAVES) &&
                     (32'(load_slot) < TABLE_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mwo_pkg::ST_IDLE;
      cnt       <= '0;
      phase_acc <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (tick_acc) begin
        phase_acc <= phase_acc + phase_step;
      end
      if (state == mwo_pkg::ST_RUN) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- wave memory ----------------
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic [WAVE_W-1:0]    rd_wave;
  logic [SLOT_W-1:0]    rd_slot;
  logic signed [SW-1:0] rd_data;

  assign wr_addr = (ADDR_W'(load_bank) * ADDR_W'(NUM_WAVES) + ADDR_W'(load_wave)) *
                   ADDR_W'(TABLE_LEN) + ADDR_W'(load_slot);

  // read order per output: wave w at si, sn, then wave w+1 at si, sn
  always_comb begin
    rd_wave = cnt[2] ? wy : wx;
    if (cnt[1]) begin
      rd_wave = rd_wave + 1'b1;
    end
    rd_slot = cnt[0] ? sn : si;
    rd_addr = (ADDR_W'(bank) * ADDR_W'(NUM_WAVES) + ADDR_W'(rd_wave)) *
              ADDR_W'(TABLE_LEN) + ADDR_W'(rd_slot);
  end

  mwo_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (write_acc && wr_ok),
    .wr_addr (wr_addr),
    .wr_data (load_value),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------- datapath ----------------
  logic [POS_W-1:0] pos;
  assign pos = {{LEN_W{1'b0}}, phase_acc} * POS_W'(TABLE_LEN);

  // shared interpolator: a + floor((b - a) * t / 4096)
  logic signed [SW-1:0]   lp_a, lp_b, lp_res;
  logic [TW-1:0]          lp_t;
  logic signed [SW:0]     lp_diff;
  logic signed [SW+TW:0]  lp_prod;
  logic signed [SW-1:0]   mix_sh;
  logic signed [mwo_pkg::OUT_W-1:0] mix_sat;

  always_comb begin
    if (rd_valid) begin
      lp_a = hold;
      lp_b = rd_data;
      lp_t = sf;
    end else if (cnt == mwo_pkg::STEP_MIX_Y) begin
      lp_a = ph[2];
      lp_b = ph[3];
      lp_t = fy;
    end else begin
      lp_a = ph[0];
      lp_b = ph[1];
      lp_t = fx;
    end
    lp_diff = {lp_b[SW-1], lp_b} - {lp_a[SW-1], lp_a};
    lp_prod = lp_diff * $signed({1'b0, lp_t});
    lp_res  = lp_a + lp_prod[FW +: SW];
    mix_sh  = lp_res >>> mwo_pkg::OUT_SHIFT;
    if (mix_sh > mwo_pkg::OUT_MAX) begin
      mix_sat = mwo_pkg::OUT_W'(mwo_pkg::OUT_MAX);
    end else if (mix_sh < mwo_pkg::OUT_MIN) begin
      mix_sat = mwo_pkg::OUT_W'(mwo_pkg::OUT_MIN);
    end else begin
      mix_sat = mix_sh[mwo_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      {wx, fx} <= pick_wave(morph_x);
      {wy, fy} <= pick_wave(morph_y);
      bank     <= (32'(alt_bank) > NUM_BANKS - 1) ? BANK_W'(NUM_BANKS - 1) : BANK_W'(alt_bank);
    end
    if (state == mwo_pkg::ST_POS) begin
      si <= pos[32 +: SLOT_W];
      sn <= (32'(pos[32 +: SLOT_W]) == TABLE_LEN - 1) ? '0 : pos[32 +: SLOT_W] + 1'b1;
      sf <= {1'b0, pos[20 +: FW]};
    end
    rd_tag <= cnt[2:0];
    if (rd_valid) begin
      if (!rd_tag[0]) begin
        hold <= rd_data;
      end else begin
        ph[rd_tag[2:1]] <= lp_res;
      end
    end
    if (!rd_valid && state == mwo_pkg::ST_RUN && cnt == mwo_pkg::STEP_MIX_X) begin
      res_x <= mix_sat;
    end
    if (!rd_valid && state == mwo_pkg::ST_RUN && cnt == mwo_pkg::STEP_MIX_Y) begin
      res_y <= mix_sat;
    end
    // outputs move only when the previous item has been taken
    if (load_out) begin
      first_out  <= res_x;
      second_out <= res_y;
    end
  end

endmodule

// ===== sv/mwo_checker.sv =====
// ----------------------------------------------------------------------------
// mwo_checker
// port level checks of the morphing wavetable oscillator
// ----------------------------------------------------------------------------
module mwo_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                kind,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mwo_pkg::OUT_W-1:0]    first_out,
  input logic signed [mwo_pkg::OUT_W-1:0]    second_out
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_out) && $stable(second_out))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

  // a write item with nothing pending gives no result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind && !out_valid |=> !out_valid)
    else $error("write item produced a result");

  // a tick item occupies the block
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !kind |=> !in_ready)
    else $error("new item taken while a tick is in progress");

endmodule

bind morphing_wavetable_oscillator mwo_checker u_mwo_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .kind       (kind),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .first_out  (first_out),
  .second_out (second_out)
);

// ===== tb/morphing_wavetable_oscillator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morphing_wavetable_oscillator_tb
// loads the wave memory and runs oscillator ticks through random handshake
// pacing, predicting every output sample and comparing it with the block
// ----------------------------------------------------------------------------
module morphing_wavetable_oscillator_tb;

  localparam int NUM_WAVES  = 16;
  localparam int TABLE_LEN  = 256;
  localparam int NUM_BANKS  = 2;
  localparam int MEM_DEPTH  = NUM_BANKS * NUM_WAVES * TABLE_LEN;
  localparam int ITEM_GOAL  = 1800;
  localparam int CYCLE_CAP  = 900000;
  localparam int DRAIN_WAIT = 30;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct {
    logic                kind;
    logic [31:0]         phase_step;
    logic                alt_bank;
    logic [11:0]         morph_x;
    logic [11:0]         morph_y;
    logic                load_bank;
    logic [3:0]          load_wave;
    logic [7:0]          load_slot;
    logic signed [15:0]  load_value;
  } osc_item_t;

  typedef struct {
    logic signed [11:0] first_out;
    logic signed [11:0] second_out;
  } sample_t;

  class osc_scoreboard;
    logic signed [15:0] wave_mem [MEM_DEPTH];
    logic [31:0]        phase;
    sample_t            pending_samples [$];
    int                 errors;
    int                 checked;

    function new();
      phase   = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function int wave_of(logic [11:0] m);
      int p;
      p = int'(m) * (NUM_WAVES - 1);
      if ((p >> 12) > NUM_WAVES - 2) return NUM_WAVES - 2;
      return p >> 12;
    endfunction

    function int lerp_q12(int a, int b, int t);
      return a + (((b - a) * t) >>> 12);
    endfunction

    function int sample_at(logic bank, int wave, int slot);
      return int'(wave_mem[(int'(bank) * NUM_WAVES + wave) * TABLE_LEN + slot]);
    endfunction

    function logic signed [11:0] render(logic bank, logic [11:0] m, int si, int sn, int sf);
      int wi, wf, sa, sb, v;
      wi = wave_of(m);
      // top position lands exactly on the last wave
      wf = (m == mwo_pkg::MORPH_TOP) ? int'(mwo_pkg::Q12_ONE)
                                     : ((int'(m) * (NUM_WAVES - 1)) & 'hFFF);
      sa = lerp_q12(sample_at(bank, wi, si), sample_at(bank, wi, sn), sf);
      sb = lerp_q12(sample_at(bank, wi + 1, si), sample_at(bank, wi + 1, sn), sf);
      v = lerp_q12(sa, sb, wf) >>> mwo_pkg::OUT_SHIFT;
      if (v > mwo_pkg::OUT_MAX) v = mwo_pkg::OUT_MAX;
      if (v < mwo_pkg::OUT_MIN) v = mwo_pkg::OUT_MIN;
      return v[11:0];
    endfunction

    function void absorb_item(osc_item_t it);
      logic [63:0] pos;
      int          si, sn, sf;
      sample_t     s;
      if (it.kind == KIND_WRITE) begin
        wave_mem[(int'(it.load_bank) * NUM_WAVES + int'(it.load_wave)) * TABLE_LEN
                 + int'(it.load_slot)] = it.load_value;
      end else begin
        phase = phase + it.phase_step;
        pos = {32'd0, phase} * 64'(TABLE_LEN);
        si = int'(pos >> 32);
        sn = (si + 1 >= TABLE_LEN) ? 0 : si + 1;
        sf = int'((pos >> 20) & 64'hFFF);
        s.first_out  = render(it.alt_bank, it.morph_x, si, sn, sf);
        s.second_out = render(it.alt_bank, it.morph_y, si, sn, sf);
        pending_samples.push_back(s);
      end
    endfunction

    function void compare_sample(logic signed [11:0] f, logic signed [11:0] s);
      sample_t e;
      if (pending_samples.size() == 0) begin
        $error("result with no item waiting: first_out %0d second_out %0d", f, s);
        errors++;
        return;
      end
      e = pending_samples.pop_front();
      checked++;
      if (f !== e.first_out) begin
        $error("first_out: expected %0d, actual %0d", e.first_out, f);
        errors++;
      end
      if (s !== e.second_out) begin
        $error("second_out: expected %0d, actual %0d", e.second_out, s);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                kind;
  logic [31:0]         phase_step;
  logic                alt_bank;
  logic [11:0]         morph_x;
  logic [11:0]         morph_y;
  logic                load_bank;
  logic [3:0]          load_wave;
  logic [7:0]          load_slot;
  logic signed [15:0]  load_value;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [11:0]  first_out;
  logic signed [11:0]  second_out;

  osc_scoreboard sb;
  bit            written [MEM_DEPTH];
  logic [31:0]   gen_phase;
  int            items_sent;
  int            n_ticks;
  int            n_writes;
  int            burst_left;
  bit            steady;
  int            cycles = 0;
  int            rx_mode = 0;
  int            rx_hold = 0;

  morphing_wavetable_oscillator #(
    .NUM_WAVES(NUM_WAVES),
    .TABLE_LEN(TABLE_LEN),
    .NUM_BANKS(NUM_BANKS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .phase_step(phase_step),
    .alt_bank(alt_bank),
    .morph_x(morph_x),
    .morph_y(morph_y),
    .load_bank(load_bank),
    .load_wave(load_wave),
    .load_slot(load_slot),
    .load_value(load_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .first_out(first_out),
    .second_out(second_out)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver changes its stall habit every so often
  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_hold = $urandom_range(20, 200);
    end else begin
      rx_hold = rx_hold - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 19) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.compare_sample(first_out, second_out);
  end

  task automatic send_item(osc_item_t it);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    kind       <= it.kind;
    phase_step <= it.phase_step;
    alt_bank   <= it.alt_bank;
    morph_x    <= it.morph_x;
    morph_y    <= it.morph_y;
    load_bank  <= it.load_bank;
    load_wave  <= it.load_wave;
    load_slot  <= it.load_slot;
    load_value <= it.load_value;
    do @(posedge clk); while (!in_ready);
    sb.absorb_item(it);
    items_sent++;
  endtask

  task automatic send_write(logic bank, logic [3:0] wave, logic [7:0] slot,
                            logic signed [15:0] value);
    osc_item_t it;
    it.kind       = KIND_WRITE;
    it.phase_step = $urandom;
    it.alt_bank   = 1'($urandom);
    it.morph_x    = 12'($urandom);
    it.morph_y    = 12'($urandom);
    it.load_bank  = bank;
    it.load_wave  = wave;
    it.load_slot  = slot;
    it.load_value = value;
    send_item(it);
    written[{bank, wave, slot}] = 1'b1;
    n_writes++;
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_morph();
    case ($urandom_range(0, 6))
      0: return 12'd0;
      1: return mwo_pkg::MORPH_TOP;
      default: return 12'($urandom);
    endcase
  endfunction

  // loads every entry that the tick is about to read, then sends the tick
  task automatic send_tick(logic [31:0] step, logic alt, logic [11:0] mx, logic [11:0] my);
    osc_item_t   it;
    logic [31:0] next_phase;
    logic [7:0]  slots [2];
    int          waves [4];
    next_phase = gen_phase + step;
    slots[0] = next_phase[31:24];
    slots[1] = next_phase[31:24] + 8'd1;
    waves[0] = sb.wave_of(mx);
    waves[1] = waves[0] + 1;
    waves[2] = sb.wave_of(my);
    waves[3] = waves[2] + 1;
    foreach (waves[i])
      foreach (slots[j])
        if (!written[{alt, 4'(waves[i]), slots[j]}])
          send_write(alt, 4'(waves[i]), slots[j], pick_value());
    it.kind       = KIND_TICK;
    it.phase_step = step;
    it.alt_bank   = alt;
    it.morph_x    = mx;
    it.morph_y    = my;
    it.load_bank  = 1'($urandom);
    it.load_wave  = 4'($urandom);
    it.load_slot  = 8'($urandom);
    it.load_value = 16'($urandom);
    send_item(it);
    gen_phase = next_phase;
    n_ticks++;
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return 32'($urandom_range(0, 32'h00FFFFFF));
      3: return 32'hFFFFFFFF - 32'($urandom_range(0, 32'h00FFFFFF));
      4: return {8'($urandom), 24'd0};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    kind       = KIND_TICK;
    phase_step = '0;
    alt_bank   = 1'b0;
    morph_x    = '0;
    morph_y    = '0;
    load_bank  = 1'b0;
    load_wave  = '0;
    load_slot  = '0;
    load_value = '0;
    gen_phase  = '0;
    items_sent = 0;
    n_ticks    = 0;
    n_writes   = 0;
    burst_left = 0;
    steady     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // top corner of the alternate bank, wrapping slot index
    send_write(1'b1, 4'd15, 8'd255, 16'sh7FFF);
    send_write(1'b1, 4'd15, 8'd0,   16'sh8000);
    send_write(1'b1, 4'd14, 8'd255, 16'sh8000);
    send_write(1'b1, 4'd14, 8'd0,   16'sh7FFF);
    send_tick(32'hFF000000, 1'b1, mwo_pkg::MORPH_TOP, mwo_pkg::MORPH_TOP);
    send_tick(32'd0, 1'b1, mwo_pkg::MORPH_TOP, 12'd4094);
    // bottom corner of the normal bank, accumulator wraps to zero
    send_write(1'b0, 4'd0, 8'd0, 16'sh8000);
    send_write(1'b0, 4'd0, 8'd1, 16'sh7FFF);
    send_write(1'b0, 4'd1, 8'd0, 16'sh7FFF);
    send_write(1'b0, 4'd1, 8'd1, 16'sh8000);
    send_tick(32'h01000000, 1'b0, 12'd0, 12'd0);
    send_tick(32'h00800000, 1'b0, 12'd0, 12'd273);
    send_tick(32'hFFFFFFFF, 1'b0, 12'd0, 12'd1);
    send_tick(32'h00123456, 1'b0, 12'd2048, 12'd1000);

    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 299) == 0) steady = !steady;
      if ($urandom_range(0, 99) < 55)
        send_tick(pick_step(), 1'($urandom), pick_morph(), pick_morph());
      else
        send_write(1'($urandom), 4'($urandom), 8'($urandom), pick_value());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d ticks and %0d memory writes, %0d output samples compared",
             n_ticks, n_writes, sb.checked);
    if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
